@@ hdl/pba_pkg.sv @@
// Shared types, constants and codes for the pool block allocator.
// No dependencies; every other file imports this package.
package pba_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W      = ADDR_BITS + 1;

  localparam logic [LEN_W-1:0] ADDR_SPAN = {1'b1, {ADDR_BITS{1'b0}}};
  localparam logic [LEN_W-1:0] POOL_RESET = ADDR_SPAN;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_BLOCKS - 1);
  localparam logic [CNT_W-1:0] SCAN_CNT  = CNT_W'(MAX_BLOCKS);

  // Request codes
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] blk_start;
    logic [LEN_W-1:0]     blk_end;
  } entry_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_W-1:0]     addr;
    logic [ADDR_BITS-1:0] blk_start;
    logic [LEN_W-1:0]     blk_end;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_clr_t;

  typedef struct packed {
    logic                 exact_found;
    logic [IDX_W-1:0]     exact_idx;
    logic [LEN_W-1:0]     exact_end;
    logic                 empty_found;
    logic [IDX_W-1:0]     empty_idx;
    logic                 best_found;
    logic [IDX_W-1:0]     best_idx;
    logic [ADDR_BITS-1:0] best_start;
  } scan_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    P_ALLOC_FREED,
    P_ALLOC_LIVE,
    P_FREE_LIVE,
    P_FREE_FREED,
    P_QUERY
  } phase_t;

endpackage

@@ hdl/pba_table.sv @@
// Block table: start/end memory with registered read, plus per-entry valid flops.
// Depends on pba_pkg.
module pba_table import pba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_addr,
  input  tbl_wr_t          wr,
  input  tbl_clr_t         clr,
  output entry_t           rd_entry
);

  logic [ADDR_BITS-1:0]  start_mem [MAX_BLOCKS];
  logic [LEN_W-1:0]      end_mem   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] valid;
  logic [ADDR_BITS-1:0]  rd_start;
  logic [LEN_W-1:0]      rd_end;
  logic                  rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      start_mem[wr.addr] <= wr.blk_start;
      end_mem[wr.addr]   <= wr.blk_end;
    end
    rd_start <= start_mem[rd_addr];
    rd_end   <= end_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clr.en) begin
        valid[clr.addr] <= 1'b0;
      end
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_entry = '{valid: rd_valid, blk_start: rd_start, blk_end: rd_end};

endmodule

@@ hdl/pba_scan.sv @@
// Shared compare unit: takes one table entry per step and keeps the exact match,
// the first empty slot and the lowest-start entry long enough. Depends on pba_pkg.
module pba_scan import pba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic                 step,
  input  logic [IDX_W-1:0]     idx,
  input  entry_t               entry,
  input  logic [ADDR_BITS-1:0] key,
  input  logic [LEN_W-1:0]     size,
  output scan_res_t            res
);

  logic [LEN_W-1:0] span;
  logic             is_exact;
  logic             is_empty;
  logic             better;

  always_comb begin
    span     = entry.blk_end - LEN_W'(entry.blk_start);
    is_exact = entry.valid && (entry.blk_start == key);
    is_empty = !entry.valid;
    better   = entry.valid && (span >= size) &&
               (!res.best_found || (entry.blk_start < res.best_start));
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      res <= '0;
    end else if (step) begin
      if (is_exact && !res.exact_found) begin
        res.exact_found <= 1'b1;
        res.exact_idx   <= idx;
        res.exact_end   <= entry.blk_end;
      end
      if (is_empty && !res.empty_found) begin
        res.empty_found <= 1'b1;
        res.empty_idx   <= idx;
      end
      if (better) begin
        res.best_found <= 1'b1;
        res.best_idx   <= idx;
        res.best_start <= entry.blk_start;
      end
    end
  end

endmodule

@@ hdl/pool_block_allocator.sv @@
// Query: one live-table scan from input transfer to result.
// Allocate and free: freed and live scans back to back, shorter when the first scan settles
// the answer. The next input is taken after the result enters the output register.
// Each scan reads the table's single port one entry per cycle into the shared compare unit.
// Synchronous reset clears valid bits at once (no clearing pass), bump offset to zero,
// pool size to 65536.
module pool_block_allocator import pba_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic [ADDR_BITS-1:0] block_offset,
  input  logic [LEN_W-1:0]     request_size,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic [ADDR_BITS-1:0] result_offset,
  output logic [LEN_W-1:0]     result_length
);

  state_t               state, state_next;
  phase_t               phase, phase_next;
  logic                 from_free, from_free_next;
  logic [LEN_W-1:0]     pool_size;
  logic [LEN_W-1:0]     bump;
  logic [ADDR_BITS-1:0] off_r;
  logic [LEN_W-1:0]     sz_r;
  logic [ADDR_BITS-1:0] key;
  logic [IDX_W-1:0]     hit_idx;
  logic [IDX_W-1:0]     li_idx;
  logic [LEN_W-1:0]     li_end;
  logic [CNT_W-1:0]     iss;
  logic                 step_v;
  logic [IDX_W-1:0]     step_idx;
  logic [1:0]           res_status;
  logic [ADDR_BITS-1:0] res_off;
  logic [LEN_W-1:0]     res_len;

  tbl_wr_t   live_wr, freed_wr;
  tbl_clr_t  live_clr, freed_clr;
  entry_t    live_rd, freed_rd, scan_entry;
  scan_res_t sres;
  logic      scan_clr;
  logic      use_live;

  logic [LEN_W:0]   bump_sum;
  logic [LEN_W-1:0] limit;
  logic             bump_ok;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;
  logic             out_load;
  logic             scan_last;

  pba_table u_live (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (iss[IDX_W-1:0]),
    .wr       (live_wr),
    .clr      (live_clr),
    .rd_entry (live_rd)
  );

  pba_table u_freed (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (iss[IDX_W-1:0]),
    .wr       (freed_wr),
    .clr      (freed_clr),
    .rd_entry (freed_rd)
  );

  pba_scan u_scan (
    .clk   (clk),
    .rst   (rst),
    .clr   (scan_clr),
    .step  (step_v),
    .idx   (step_idx),
    .entry (scan_entry),
    .key   (key),
    .size  (sz_r),
    .res   (sres)
  );

  always_comb begin
    bump_sum  = {1'b0, bump} + {1'b0, sz_r};
    limit     = (pool_size > ADDR_SPAN) ? ADDR_SPAN : pool_size;
    bump_ok   = !bump[ADDR_BITS] && (bump_sum <= {1'b0, limit});
    slot_ok   = sres.exact_found || sres.empty_found;
    slot_idx  = sres.exact_found ? sres.exact_idx : sres.empty_idx;
    out_load  = !out_valid || out_ready;
    scan_last = step_v && (step_idx == LAST_IDX);
    use_live  = (phase != P_ALLOC_FREED) && (phase != P_FREE_FREED);
    scan_entry = use_live ? live_rd : freed_rd;
  end

  // Next state
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    from_free_next = from_free;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (opcode == OP_ALLOC) begin
            phase_next = P_ALLOC_FREED;
            state_next = S_SCAN;
          end else if (opcode == OP_FREE) begin
            phase_next = P_FREE_LIVE;
            state_next = S_SCAN;
          end else if (opcode == OP_QUERY) begin
            phase_next = P_QUERY;
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_DONE;
        unique case (phase)
          P_ALLOC_FREED: begin
            if (sres.best_found || bump_ok) begin
              phase_next     = P_ALLOC_LIVE;
              from_free_next = sres.best_found;
              state_next     = S_SCAN;
            end
          end
          P_FREE_LIVE: begin
            if (sres.exact_found) begin
              phase_next = P_FREE_FREED;
              state_next = S_SCAN;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready  = (state == S_IDLE);
    scan_clr  = (state != S_SCAN);
    live_wr   = '0;
    freed_wr  = '0;
    live_clr  = '0;
    freed_clr = '0;
    if (state == S_EVAL && slot_ok) begin
      if (phase == P_ALLOC_LIVE) begin
        live_wr = '{en: 1'b1, addr: slot_idx, blk_start: key,
                    blk_end: LEN_W'(key) + sz_r};
        if (from_free) begin
          freed_clr = '{en: 1'b1, addr: hit_idx};
        end
      end else if (phase == P_FREE_FREED) begin
        freed_wr = '{en: 1'b1, addr: slot_idx, blk_start: off_r, blk_end: li_end};
        live_clr = '{en: 1'b1, addr: li_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_QUERY;
      from_free <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      from_free <= from_free_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= POOL_RESET;
    end else if (cfg_we) begin
      pool_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bump <= '0;
    end else if (state == S_EVAL && phase == P_ALLOC_LIVE && slot_ok && !from_free) begin
      bump <= bump_sum[LEN_W-1:0];
    end
  end

  // Issue one table address a cycle; the read data lines up with step_v
  always_ff @(posedge clk) begin
    if (rst) begin
      iss    <= '0;
      step_v <= 1'b0;
    end else if (state == S_SCAN) begin
      if (iss != SCAN_CNT) begin
        iss <= iss + CNT_W'(1);
      end
      step_v <= (iss != SCAN_CNT);
    end else begin
      iss    <= '0;
      step_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    step_idx <= iss[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          off_r      <= block_offset;
          sz_r       <= request_size;
          key        <= block_offset;
          res_status <= ST_NOT_FOUND;
          res_off    <= '0;
          res_len    <= '0;
        end
      end
      S_EVAL: begin
        unique case (phase)
          P_ALLOC_FREED: begin
            priority if (sres.best_found) begin
              key     <= sres.best_start;
              hit_idx <= sres.best_idx;
            end else if (bump_ok) begin
              key <= bump[ADDR_BITS-1:0];
            end else begin
              res_status <= ST_EXHAUSTED;
            end
          end
          P_ALLOC_LIVE: begin
            if (slot_ok) begin
              res_status <= ST_OK;
              res_off    <= key;
              res_len    <= sz_r;
            end else begin
              res_status <= ST_FULL;
            end
          end
          P_FREE_LIVE: begin
            if (sres.exact_found) begin
              li_idx <= sres.exact_idx;
              li_end <= sres.exact_end;
            end
          end
          P_FREE_FREED: begin
            if (slot_ok) begin
              res_status <= ST_OK;
              res_off    <= off_r;
              res_len    <= li_end - LEN_W'(off_r);
            end else begin
              res_status <= ST_FULL;
            end
          end
          P_QUERY: begin
            if (sres.exact_found) begin
              res_status <= ST_OK;
              res_off    <= off_r;
              res_len    <= sres.exact_end - LEN_W'(off_r);
            end
          end
          default: begin
            res_status <= ST_NOT_FOUND;
          end
        endcase
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // Output register: a finished result waits here for its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_load) begin
      status        <= res_status;
      result_offset <= res_off;
      result_length <= res_len;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in progress");

  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (step_v && step_idx != LAST_IDX) |=>
      (step_v && step_idx == $past(step_idx) + IDX_W'(1)))
    else $error("table scan skipped or stalled an entry");

  a_bump_range: assert property (@(posedge clk) disable iff (rst)
    bump <= ADDR_SPAN)
    else $error("bump offset beyond address space");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (result_offset == '0 && result_length == '0))
    else $error("failed request returned a non-zero block");
`endif

endmodule
